// ----- rtl/tw9p_pkg.sv -----
// ----------------------------------------------------------------------------
// tw9p_pkg
// Shared types and codes for the three-wire nine-bit packer.
// ----------------------------------------------------------------------------
package tw9p_pkg;

   typedef enum logic [1:0] {
      OP_SET_DC = 2'd0,
      OP_START  = 2'd1,
      OP_SEND   = 2'd2,
      OP_END    = 2'd3
   } op_type;

   typedef struct packed {
      op_type      opcode;
      logic        dc_value;
      logic [7:0]  data_byte;
   } item_type;

   typedef struct packed {
      logic [7:0]  out_byte;
      logic        has_byte;
      logic        last;
   } result_type;

   // control from the sequencer into the packer
   typedef struct packed {
      logic        consume;
      logic        phase;
   } pack_ctl_type;

   // status from the packer back to the sequencer
   typedef struct packed {
      logic        has_result;
      logic        two_results;
   } pack_stat_type;

endpackage

// ----- rtl/tw9p_pack.sv -----
// ----------------------------------------------------------------------------
// tw9p_pack
// Stream state (D/C flag, pending bits) and the per-item packing logic.
// ----------------------------------------------------------------------------
module tw9p_pack
   import tw9p_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  item_type      item,
   input  pack_ctl_type  ctl,
   output pack_stat_type stat,
   output result_type    result
);

   logic        dc_flag_ff, dc_flag_in;
   logic [6:0]  bits_ff, bits_in;
   logic [2:0]  count_ff, count_in;

   logic [15:0] acc;
   logic [3:0]  shift;
   logic [15:0] mask;
   logic [15:0] acc_shifted;
   logic [15:0] pad_shifted;
   logic        full;

   always_comb begin
      acc         = {bits_ff, dc_flag_ff, item.data_byte};
      shift       = {1'b0, count_ff} + 4'd1;
      mask        = (16'd1 << shift) - 16'd1;
      acc_shifted = acc >> shift;
      pad_shifted = {9'd0, bits_ff} << (4'd8 - {1'b0, count_ff});
      full        = (count_ff == 3'd7);
   end

   always_comb begin
      dc_flag_in       = dc_flag_ff;
      bits_in          = bits_ff;
      count_in         = count_ff;
      stat.has_result  = 1'b0;
      stat.two_results = 1'b0;
      result.out_byte  = 8'd0;
      result.has_byte  = 1'b0;
      result.last      = 1'b0;
      case (item.opcode)
         OP_SET_DC: begin
            dc_flag_in = item.dc_value;
         end
         OP_START: begin
            bits_in  = 7'd0;
            count_in = 3'd0;
         end
         OP_SEND: begin
            stat.has_result  = 1'b1;
            stat.two_results = full;
            result.has_byte  = 1'b1;
            if (full) begin
               result.out_byte = ctl.phase ? acc[7:0] : acc[15:8];
               bits_in         = 7'd0;
               count_in        = 3'd0;
            end else begin
               result.out_byte = acc_shifted[7:0];
               bits_in         = acc[6:0] & mask[6:0];
               count_in        = count_ff + 3'd1;
            end
         end
         OP_END: begin
            stat.has_result = 1'b1;
            result.out_byte = (count_ff != 3'd0) ? pad_shifted[7:0] : 8'd0;
            result.has_byte = (count_ff != 3'd0);
            result.last     = 1'b1;
            bits_in         = 7'd0;
            count_in        = 3'd0;
         end
         default: begin
            dc_flag_in = dc_flag_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dc_flag_ff <= 1'b0;
         bits_ff    <= 7'd0;
         count_ff   <= 3'd0;
      end else if (ctl.consume) begin
         dc_flag_ff <= dc_flag_in;
         bits_ff    <= bits_in;
         count_ff   <= count_in;
      end
   end

endmodule

// ----- rtl/tw9p_outreg.sv -----
// ----------------------------------------------------------------------------
// tw9p_outreg
// Result register between the packer and the result channel.
// ----------------------------------------------------------------------------
module tw9p_outreg
   import tw9p_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       load,
   input  result_type result,
   input  logic       take,
   output logic       free,
   output logic       valid,
   output result_type held
);

   logic       valid_ff, valid_in;
   result_type held_ff;

   assign free     = !valid_ff || take;
   assign valid_in = load || (valid_ff && !take);
   assign valid    = valid_ff;
   assign held     = held_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         held_ff <= result;
      end
   end

endmodule

// ----- rtl/three_wire_nine_bit_packer.sv -----
// ----------------------------------------------------------------------------
// three_wire_nine_bit_packer
// Packs 9-bit D/C-prefixed words into a byte stream for a three-wire panel.
// ----------------------------------------------------------------------------
// An accepted command sits in an input register while the packer forms its
// result; the result then waits in an output register. Set-flag, start and
// end commands, and a send that completes one byte, yield at most one result;
// a send that completes two bytes emits them one after the other, since both
// leave through the single result channel. With the result side ready, a new
// command is accepted every cycle but while such a send emits its first byte.
// ----------------------------------------------------------------------------
module three_wire_nine_bit_packer
   import tw9p_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [0] dc_value, [8:1] data_byte, rest zero
   input  logic [1:0]  req_tuser,   // [1:0] opcode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [7:0] out_byte
   output logic        rsp_tuser,   // [0] has_byte
   output logic        rsp_tlast
);

   logic          in_valid_ff, in_valid_in;
   item_type      in_item_ff;
   logic          phase_ff, phase_in;
   logic          req_take;
   logic          emit;
   logic          out_free;
   logic          out_valid;
   pack_ctl_type  ctl;
   pack_stat_type stat;
   result_type    result;
   result_type    held;

   assign emit = in_valid_ff && stat.has_result && out_free;

   always_comb begin
      ctl.phase   = phase_ff;
      ctl.consume = in_valid_ff &&
                    (!stat.has_result ||
                     (out_free && (!stat.two_results || phase_ff)));
   end

   assign req_tready  = !in_valid_ff || ctl.consume;
   assign req_take    = req_tvalid && req_tready;
   assign in_valid_in = req_take || (in_valid_ff && !ctl.consume);
   assign phase_in    = ctl.consume ? 1'b0 :
                        ((emit && stat.two_results) ? 1'b1 : phase_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         phase_ff    <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
         phase_ff    <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_item_ff.opcode    <= op_type'(req_tuser);
         in_item_ff.dc_value  <= req_tdata[0];
         in_item_ff.data_byte <= req_tdata[8:1];
      end
   end

   tw9p_pack u_pack (
      .clock  (clock),
      .reset  (reset),
      .item   (in_item_ff),
      .ctl    (ctl),
      .stat   (stat),
      .result (result)
   );

   tw9p_outreg u_outreg (
      .clock  (clock),
      .reset  (reset),
      .load   (emit),
      .result (result),
      .take   (rsp_tready),
      .free   (out_free),
      .valid  (out_valid),
      .held   (held)
   );

   assign rsp_tvalid = out_valid;
   assign rsp_tdata  = held.out_byte;
   assign rsp_tuser  = held.has_byte;
   assign rsp_tlast  = held.last;

   a_phase_only_in_send: assert property (@(posedge clock) disable iff (reset)
      phase_ff |-> (in_valid_ff && in_item_ff.opcode == OP_SEND && stat.two_results))
      else $error("second-byte phase outside a two-byte send");

   a_emit_shows: assert property (@(posedge clock) disable iff (reset)
      emit |=> rsp_tvalid)
      else $error("emitted result not presented");

   a_hold_blocks_input: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !ctl.consume) |-> !req_tready)
      else $error("input accepted while item still pending");

   a_marker_is_empty: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser) |-> (rsp_tlast && rsp_tdata == 8'd0))
      else $error("bare end marker carries data");

endmodule

// ----- bench/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Stream-level testbench for the three-wire nine-bit packer.
// ----------------------------------------------------------------------------
// Commands go in on the req_ stream; a behavioral packer in the bench tracks
// the D/C flag and the partially filled wire byte, and queues the wire bytes
// each accepted command should produce. Every rsp_ transfer is compared field
// by field with the oldest queued byte. Directed cases cover the corners of
// the bit packing; random frames and noise follow, with random gaps on both
// sides, a long receiver hold-off, a sender pause and a stretch of no gaps.
// ----------------------------------------------------------------------------
module tb
   import tw9p_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int QUIET_LIMIT  = 1000;
   localparam int HOLD_CYCLES  = 80;
   localparam int SETTLE_TICKS = 8;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata  = '0;   // [0] dc_value, [8:1] data_byte
   logic [1:0]  req_tuser  = '0;   // [1:0] opcode
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;         // [7:0] out_byte
   logic        rsp_tuser;         // [0] has_byte
   logic        rsp_tlast;

   result_type  wire_bytes_due[$];
   logic        dc_now      = 1'b0;
   logic [6:0]  carry_bits  = '0;
   logic [2:0]  carry_count = '0;

   int   errors       = 0;
   int   items_sent   = 0;
   int   quiet_cycles = 0;
   bit   req_gaps_on  = 1'b1;
   bit   rsp_gaps_on  = 1'b1;
   bit   rsp_hold_req = 1'b0;

   three_wire_nine_bit_packer dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // mostly zero, sometimes short, rarely long
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 19);
      if (roll < 12) return 0;
      if (roll < 18) return $urandom_range(1, 3);
      return $urandom_range(6, 25);
   endfunction

   // expected wire bytes for one accepted command
   function automatic void predict_wire_bytes(item_type it);
      logic [15:0] acc;
      result_type  r;
      int          n;
      case (it.opcode)
         OP_SET_DC: dc_now = it.dc_value;
         OP_START: begin
            carry_bits  = '0;
            carry_count = '0;
         end
         OP_SEND: begin
            acc = {carry_bits, dc_now, it.data_byte};
            n   = int'(carry_count) + 9;
            while (n >= 8) begin
               n -= 8;
               r.out_byte = 8'(acc >> n);
               r.has_byte = 1'b1;
               r.last     = 1'b0;
               wire_bytes_due.push_back(r);
            end
            carry_count = 3'(n);
            carry_bits  = 7'(acc & ((16'd1 << n) - 16'd1));
         end
         OP_END: begin
            r.last = 1'b1;
            if (carry_count != 0) begin
               r.out_byte = 8'({1'b0, carry_bits} << (8 - int'(carry_count)));
               r.has_byte = 1'b1;
            end else begin
               r.out_byte = '0;
               r.has_byte = 1'b0;
            end
            wire_bytes_due.push_back(r);
            carry_bits  = '0;
            carry_count = '0;
         end
         default: ;
      endcase
   endfunction

   // called at a rising edge; returns at the edge where the transfer happens
   task automatic send_item(op_type op, logic dc, logic [7:0] data);
      item_type it;
      int       gap;
      it.opcode    = op;
      it.dc_value  = dc;
      it.data_byte = data;
      gap = req_gaps_on ? pick_gap() : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= it.opcode;
      req_tdata  <= {7'd0, it.data_byte, it.dc_value};
      do @(posedge clock); while (!req_tready);
      predict_wire_bytes(it);
      items_sent++;
   endtask

   task automatic send_random(op_type op);
      send_item(op, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
   endtask

   task automatic sender_pause_for_drain();
      req_tvalid <= 1'b0;
      wait (wire_bytes_due.size() == 0);
      repeat (SETTLE_TICKS) @(posedge clock);
   endtask

   task automatic random_frame();
      int len;
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
      if ($urandom_range(0, 2) == 0) send_random(OP_SET_DC);
      send_random(OP_START);
      repeat (len) begin
         if ($urandom_range(0, 7) == 0) send_random(OP_SET_DC);
         else send_random(OP_SEND);
      end
      send_random(OP_END);
   endtask

   task automatic random_noise();
      repeat ($urandom_range(1, 4)) send_random(op_type'($urandom_range(0, 3)));
   endtask

   task automatic random_traffic(int count);
      int stop_at;
      stop_at = items_sent + count;
      while (items_sent < stop_at) begin
         if ($urandom_range(0, 4) == 0) random_noise();
         else random_frame();
      end
   endtask

   task automatic test_directed();
      logic [7:0] pattern[8];
      pattern = '{8'hFF, 8'h00, 8'h80, 8'h01, 8'h7F, 8'hFE, 8'h55, 8'hAA};
      // send with no start straight out of reset, then a padded end
      send_item(OP_SEND, 1'b1, 8'h00);
      send_item(OP_END, 1'b1, 8'hFF);
      // end with nothing pending
      send_item(OP_END, 1'b0, 8'h00);
      send_item(OP_SET_DC, 1'b1, 8'hFF);
      send_item(OP_START, 1'b0, 8'hA5);
      // eight words walk the carry count 1..7 and back to 0
      foreach (pattern[i]) send_item(OP_SEND, 1'b0, pattern[i]);
      send_item(OP_END, 1'b1, 8'h00);
      send_item(OP_SET_DC, 1'b0, 8'h00);
      send_item(OP_START, 1'b1, 8'hFF);
      send_item(OP_SEND, 1'b1, 8'hFF);
      send_item(OP_SEND, 1'b0, 8'h01);
      send_item(OP_END, 1'b0, 8'h5A);
      // start in mid transfer drops the carried bits
      send_item(OP_SET_DC, 1'b1, 8'h00);
      send_item(OP_START, 1'b0, 8'h00);
      send_item(OP_SEND, 1'b1, 8'h3C);
      send_item(OP_START, 1'b1, 8'h00);
      send_item(OP_END, 1'b1, 8'hFF);
   endtask

   task automatic test_random_frames();
      random_traffic(420);
   endtask

   task automatic test_long_hold();
      req_gaps_on  = 1'b0;
      rsp_hold_req = 1'b1;
      send_random(OP_START);
      repeat (40) send_random(OP_SEND);
      send_random(OP_END);
      req_gaps_on = 1'b1;
   endtask

   task automatic test_sender_pause();
      random_traffic(60);
      sender_pause_for_drain();
      random_traffic(60);
   endtask

   task automatic test_no_gaps();
      req_gaps_on = 1'b0;
      rsp_gaps_on = 1'b0;
      random_traffic(160);
      req_gaps_on = 1'b1;
      rsp_gaps_on = 1'b1;
   endtask

   initial begin : stimulus
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random_frames();
      test_long_hold();
      test_sender_pause();
      test_no_gaps();
      random_traffic(60);
      sender_pause_for_drain();
      if (errors == 0 && wire_bytes_due.size() == 0) begin
         $display("three_wire_nine_bit_packer: match");
      end else begin
         $display("three_wire_nine_bit_packer: mismatch");
      end
      $finish;
   end

   initial begin : rsp_side
      int stall_left;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (rsp_hold_req) begin
            rsp_hold_req = 1'b0;
            stall_left   = HOLD_CYCLES;
         end else if (stall_left == 0 && rsp_gaps_on) begin
            stall_left = pick_gap();
         end
         if (stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   initial begin : check_results
      result_type got;
      result_type want;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) begin
            got.out_byte = rsp_tdata;
            got.has_byte = rsp_tuser;
            got.last     = rsp_tlast;
            if (wire_bytes_due.size() == 0) begin
               errors++;
               $display("%0t: unexpected transfer, expected none, actual byte %h has %b last %b",
                        $time, got.out_byte, got.has_byte, got.last);
            end else begin
               want = wire_bytes_due.pop_front();
               if (got.out_byte !== want.out_byte) begin
                  errors++;
                  $display("%0t: out_byte expected %h actual %h",
                           $time, want.out_byte, got.out_byte);
               end
               if (got.has_byte !== want.has_byte) begin
                  errors++;
                  $display("%0t: has_byte expected %b actual %b",
                           $time, want.has_byte, got.has_byte);
               end
               if (got.last !== want.last) begin
                  errors++;
                  $display("%0t: last expected %b actual %b", $time, want.last, got.last);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no transfer for %0d cycles, %0d results outstanding",
                     $time, quiet_cycles, wire_bytes_due.size());
            $display("three_wire_nine_bit_packer: mismatch");
            $finish;
         end
      end
   end

endmodule
